/* rtl/gbts_pkg.sv */
// Shared constants and types for the gap buffer text store.
package gbts_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the transaction ports
    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int MOVE_W = 14;
    localparam int IDX_W  = 12;
    localparam int POS_W  = 13;

    // Width wide enough to compare counts, move amounts and indexes
    localparam int LEN_W0 = (CNT_W > MOVE_W) ? CNT_W : MOVE_W;
    localparam int LEN_W  = ((LEN_W0 > IDX_W) ? LEN_W0 : IDX_W) + 1;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Command codes
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACKSPACE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEFT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RIGHT     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOVE      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

    // Control states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOVE = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

/* rtl/gbts_ram.sv */
// Generic simple dual-port RAM with registered, enabled read.
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/gap_buffer_text_store.sv */
// Gap buffer text store: one edit command per transaction, text in a single RAM.
// Insert, delete, backspace, read and unused codes go from the accepted input
// transaction to ST_DONE, then to the output register once its slot is free;
// cursor moves pass through ST_MOVE first, where the copy pipeline does one byte
// per cycle through the RAM read and write ports. One command is held at a time.
// Reset: cursor 0, empty text, no result pending; text RAM is not cleared.
module gap_buffer_text_store
    import gbts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [CHAR_W-1:0]        i_char_in,
    input  logic signed [MOVE_W-1:0] i_move_count,
    input  logic [IDX_W-1:0]         i_read_index,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [CHAR_W-1:0]        o_read_char,
    output logic                     o_read_valid,
    output logic [POS_W-1:0]         o_cursor_pos,
    output logic [POS_W-1:0]         o_text_length,
    output logic                     o_overflow
);

    t_state             r_state;
    logic [CNT_W-1:0]   r_cursor;
    logic [CNT_W-1:0]   r_gap;
    logic [CNT_W-1:0]   r_rem;
    logic               r_dir_left;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_pend_addr;
    logic               r_is_read;
    logic               r_rvalid;
    logic               r_ovf;
    logic               r_ovalid;

    logic               w_accept;
    logic               w_load;
    logic [CNT_W-1:0]   w_after_len;
    logic               w_move_neg;
    logic [MOVE_W-1:0]  w_move_mag;
    logic [CNT_W-1:0]   w_limit;
    logic [CNT_W-1:0]   w_move_len;
    logic               w_idx_in;
    logic [ADDR_W-1:0]  w_read_addr;
    logic               w_issue;
    logic [ADDR_W-1:0]  w_src;
    logic [ADDR_W-1:0]  w_dst;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [CHAR_W-1:0]  w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic [CHAR_W-1:0]  w_rdata;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign w_load   = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    // Bytes after the gap
    assign w_after_len = CAP_CNT - r_cursor - r_gap;

    // Move-by amount, clamped to the text end in its direction
    assign w_move_neg = i_move_count[MOVE_W-1];
    assign w_move_mag = w_move_neg ? MOVE_W'(-i_move_count) : MOVE_W'(i_move_count);
    assign w_limit    = w_move_neg ? r_cursor : w_after_len;
    assign w_move_len = (LEN_W'(w_move_mag) > LEN_W'(w_limit)) ? w_limit
                                                                : CNT_W'(w_move_mag);

    // Logical index to RAM address, skipping the gap
    assign w_idx_in    = LEN_W'(i_read_index) < LEN_W'(CAP_CNT - r_gap);
    assign w_read_addr = (LEN_W'(i_read_index) < LEN_W'(r_cursor))
                       ? ADDR_W'(i_read_index)
                       : ADDR_W'(LEN_W'(i_read_index) + LEN_W'(r_gap));

    // Copy pipeline: read source now, write destination next cycle
    assign w_issue = (r_state == ST_MOVE) && (r_rem != '0);
    assign w_src   = r_dir_left ? ADDR_W'(r_cursor - 1'b1) : ADDR_W'(r_cursor + r_gap);
    assign w_dst   = r_dir_left ? ADDR_W'(r_cursor + r_gap - 1'b1) : ADDR_W'(r_cursor);

    // RAM port muxing
    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_src;
        if (w_issue) begin
            w_re = 1'b1;
        end else if (w_accept && (i_mode == MODE_READ) && w_idx_in) begin
            w_re    = 1'b1;
            w_raddr = w_read_addr;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pend_addr;
        w_wdata = w_rdata;
        if (r_pend) begin
            w_we = 1'b1;
        end else if (w_accept && (i_mode == MODE_INSERT) && (r_gap != '0)) begin
            w_we    = 1'b1;
            w_waddr = ADDR_W'(r_cursor);
            w_wdata = i_char_in;
        end
    end

    gbts_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control, cursor and gap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cursor   <= '0;
            r_gap      <= CAP_CNT;
            r_rem      <= '0;
            r_dir_left <= 1'b0;
            r_pend     <= 1'b0;
            r_is_read  <= 1'b0;
            r_rvalid   <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_pend <= w_issue;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_is_read <= 1'b0;
                        r_rvalid  <= 1'b0;
                        r_ovf     <= 1'b0;
                        r_state   <= ST_DONE;
                        case (i_mode)
                            MODE_INSERT: begin
                                if (r_gap == '0) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cursor <= r_cursor + 1'b1;
                                    r_gap    <= r_gap - 1'b1;
                                end
                            end
                            MODE_DELETE: begin
                                if (w_after_len != '0) begin
                                    r_gap <= r_gap + 1'b1;
                                end
                            end
                            MODE_BACKSPACE: begin
                                if (r_cursor != '0) begin
                                    r_cursor <= r_cursor - 1'b1;
                                    r_gap    <= r_gap + 1'b1;
                                end
                            end
                            MODE_LEFT: begin
                                r_dir_left <= 1'b1;
                                r_rem      <= CNT_W'(r_cursor != '0);
                                r_state    <= ST_MOVE;
                            end
                            MODE_RIGHT: begin
                                r_dir_left <= 1'b0;
                                r_rem      <= CNT_W'(w_after_len != '0);
                                r_state    <= ST_MOVE;
                            end
                            MODE_MOVE: begin
                                r_dir_left <= w_move_neg;
                                r_rem      <= w_move_len;
                                r_state    <= ST_MOVE;
                            end
                            MODE_READ: begin
                                r_is_read <= 1'b1;
                                r_rvalid  <= w_idx_in;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MOVE: begin
                    if (w_issue) begin
                        r_rem    <= r_rem - 1'b1;
                        r_cursor <= r_dir_left ? (r_cursor - 1'b1) : (r_cursor + 1'b1);
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Pending copy write address
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_addr <= w_dst;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_read_char   <= (r_is_read && r_rvalid) ? w_rdata : '0;
            o_read_valid  <= r_is_read && r_rvalid;
            o_cursor_pos  <= POS_W'(r_cursor);
            o_text_length <= POS_W'(CAP_CNT - r_gap);
            o_overflow    <= r_ovf;
        end
    end

    // Cursor and gap never reach past the end of the store
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cursor} + {1'b0, r_gap}) <= {1'b0, CAP_CNT})
        else $error("cursor plus gap exceeds capacity");

    // No copy write may still be pending when a new command is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("copy write pending in idle");

    // A finished command with a free output slot shows its result next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && (r_state == ST_IDLE)))
        else $error("result not presented after load");

endmodule

/* tb/gbts_checker.sv */
// Scoreboard for the gap buffer text store: predicts each edit result and compares.
`timescale 1ns / 1ps

module gbts_checker
    import gbts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [CHAR_W-1:0]        i_char_in,
    input  logic signed [MOVE_W-1:0] i_move_count,
    input  logic [IDX_W-1:0]         i_read_index,
    // result channel
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic [CHAR_W-1:0]        i_read_char,
    input  logic                     i_read_valid,
    input  logic [POS_W-1:0]         i_cursor_pos,
    input  logic [POS_W-1:0]         i_text_length,
    input  logic                     i_overflow,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              read_valid;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  text_length;
        logic              overflow;
    } t_edit_result;

    // Logical text held as a plain byte queue; the gap never needs modeling
    logic [CHAR_W-1:0] text_q[$];
    int                caret;
    t_edit_result      edit_results_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        caret        = 0;
    end

    // Cursor move, clamped at both text ends
    function automatic void move_caret(input int amount);
        int len;
        len = text_q.size();
        if (amount < 0) begin
            caret = (-amount > caret) ? 0 : caret + amount;
        end else begin
            caret = (amount > len - caret) ? len : caret + amount;
        end
    endfunction

    // Apply one edit command to the predicted text and build its result
    function automatic t_edit_result apply_edit(
        input logic [MODE_W-1:0]        mode,
        input logic [CHAR_W-1:0]        ch,
        input logic signed [MOVE_W-1:0] amount,
        input logic [IDX_W-1:0]         idx
    );
        t_edit_result res;
        int           amt;
        res = '0;
        amt = amount;
        case (mode)
            MODE_INSERT: begin
                if (text_q.size() >= CAPACITY) begin
                    res.overflow = 1'b1;
                end else begin
                    text_q.insert(caret, ch);
                    caret++;
                end
            end
            MODE_DELETE: begin
                if (caret < text_q.size()) text_q.delete(caret);
            end
            MODE_BACKSPACE: begin
                if (caret > 0) begin
                    caret--;
                    text_q.delete(caret);
                end
            end
            MODE_LEFT:  move_caret(-1);
            MODE_RIGHT: move_caret(1);
            MODE_MOVE:  move_caret(amt);
            MODE_READ: begin
                if (int'(idx) < text_q.size()) begin
                    res.read_char  = text_q[idx];
                    res.read_valid = 1'b1;
                end
            end
            default: ;
        endcase
        res.cursor_pos  = POS_W'(caret);
        res.text_length = POS_W'(text_q.size());
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare each result transaction, then record the command accepted this edge
    always @(posedge i_clk) begin : score
        t_edit_result want;
        if (!i_rst_n) begin
            text_q.delete();
            edit_results_q.delete();
            caret = 0;
            o_pending <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (edit_results_q.size() == 0) begin
                    $display("%0t ns: result transaction with no command outstanding",
                             $time);
                    o_fail_count++;
                end else begin
                    want = edit_results_q.pop_front();
                    check_field("read_char",   16'(want.read_char),   16'(i_read_char));
                    check_field("read_valid",  16'(want.read_valid),  16'(i_read_valid));
                    check_field("cursor_pos",  16'(want.cursor_pos),  16'(i_cursor_pos));
                    check_field("text_length", 16'(want.text_length), 16'(i_text_length));
                    check_field("overflow",    16'(want.overflow),    16'(i_overflow));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                edit_results_q.push_back(apply_edit(i_mode, i_char_in, i_move_count,
                                                    i_read_index));
            end
            o_pending <= edit_results_q.size();
        end
    end

endmodule

/* tb/tb.sv */
// Top of the gap buffer text store testbench: clock, reset, edit stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import gbts_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int RANDOM_EDITS = 900;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_CYCLES  = 16;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [MODE_W-1:0]        i_mode;
    logic [CHAR_W-1:0]        i_char_in;
    logic signed [MOVE_W-1:0] i_move_count;
    logic [IDX_W-1:0]         i_read_index;
    logic                     o_valid;
    logic                     i_ready;
    logic [CHAR_W-1:0]        o_read_char;
    logic                     o_read_valid;
    logic [POS_W-1:0]         o_cursor_pos;
    logic [POS_W-1:0]         o_text_length;
    logic                     o_overflow;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    always #6 i_clk = ~i_clk;

    gap_buffer_text_store u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_char_in     (i_char_in),
        .i_move_count  (i_move_count),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_char   (o_read_char),
        .o_read_valid  (o_read_valid),
        .o_cursor_pos  (o_cursor_pos),
        .o_text_length (o_text_length),
        .o_overflow    (o_overflow)
    );

    gbts_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_ready   (o_ready),
        .i_mode        (i_mode),
        .i_char_in     (i_char_in),
        .i_move_count  (i_move_count),
        .i_read_index  (i_read_index),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_read_char   (o_read_char),
        .i_read_valid  (o_read_valid),
        .i_cursor_pos  (o_cursor_pos),
        .i_text_length (o_text_length),
        .i_overflow    (o_overflow),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= idle_len();
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One command transaction; entered and left just after a falling edge
    task automatic send_edit(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                             input logic [MOVE_W-1:0] amount,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode       = mode;
        i_char_in    = ch;
        i_move_count = amount;
        i_read_index = idx;
        i_valid      = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        @(negedge i_clk);
    endtask

    // Random edit, weighted toward inserts so the text grows a little over time
    task automatic send_random_edit();
        logic [MODE_W-1:0] mode;
        logic [MOVE_W-1:0] amount;
        logic [IDX_W-1:0]  idx;
        int                r;
        r = $urandom_range(0, 99);
        if      (r < 30) mode = MODE_INSERT;
        else if (r < 39) mode = MODE_DELETE;
        else if (r < 48) mode = MODE_BACKSPACE;
        else if (r < 56) mode = MODE_LEFT;
        else if (r < 64) mode = MODE_RIGHT;
        else if (r < 78) mode = MODE_MOVE;
        else if (r < 98) mode = MODE_READ;
        else             mode = MODE_UNUSED;
        // short moves mostly, the whole signed range sometimes
        if ($urandom_range(0, 4) != 0) amount = MOVE_W'($urandom_range(0, 32) - 16);
        else                           amount = MOVE_W'($urandom);
        // read near the text mostly, anywhere sometimes
        if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, 255));
        else                           idx = IDX_W'($urandom);
        send_edit(mode, CHAR_W'($urandom), amount, idx);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_mode       = MODE_INSERT;
        i_char_in    = '0;
        i_move_count = '0;
        i_read_index = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: edges of an empty text
        send_edit(MODE_DELETE,    8'h00, '0, '0);
        send_edit(MODE_BACKSPACE, 8'h00, '0, '0);
        send_edit(MODE_LEFT,      8'h00, '0, '0);
        send_edit(MODE_RIGHT,     8'h00, '0, '0);
        send_edit(MODE_MOVE,      8'h00, 14'sh2000, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'd0);
        send_edit(MODE_UNUSED,    8'hff, 14'sh3fff, 12'hfff);
        // Directed: small text, clamped moves, reads in and past the text
        send_edit(MODE_INSERT,    8'h00, '0, '0);
        send_edit(MODE_INSERT,    8'hff, '0, '0);
        send_edit(MODE_INSERT,    8'ha5, '0, '0);
        send_edit(MODE_LEFT,      8'h00, '0, '0);
        send_edit(MODE_MOVE,      8'h00, 14'sh1fff, '0);
        send_edit(MODE_MOVE,      8'h00, -14'sd4096, '0);
        send_edit(MODE_RIGHT,     8'h00, '0, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'd0);
        send_edit(MODE_READ,      8'h00, '0, 12'd2);
        send_edit(MODE_READ,      8'h00, '0, 12'd3);
        send_edit(MODE_READ,      8'h00, '0, 12'hfff);
        send_edit(MODE_DELETE,    8'h00, '0, '0);
        send_edit(MODE_BACKSPACE, 8'h00, '0, '0);
        send_edit(MODE_MOVE,      8'h00, 14'sd0, '0);
        send_edit(MODE_INSERT,    8'h5a, '0, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'd1);

        // Random edits, with one quiet stretch and one full drain
        for (int n = 0; n < RANDOM_EDITS; n++) begin
            quiet = (n >= 300 && n < 400);
            if (n == 600) begin
                i_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send_random_edit();
        end
        quiet = 1'b0;

        // Long clamped copies in both directions and the last index
        send_edit(MODE_READ,      8'h00, '0, 12'hfff);
        send_edit(MODE_MOVE,      8'h00, 14'sh2000, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'hfff);
        send_edit(MODE_MOVE,      8'h00, 14'sh1fff, '0);
        send_edit(MODE_DELETE,    8'h00, '0, '0);
        send_edit(MODE_INSERT,    8'h3c, '0, '0);
        send_edit(MODE_LEFT,      8'h00, '0, '0);
        send_edit(MODE_BACKSPACE, 8'h00, '0, '0);
        send_edit(MODE_INSERT,    8'hc3, '0, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'hffe);
        send_edit(MODE_MOVE,      8'h00, -14'sd2048, '0);
        send_edit(MODE_READ,      8'h00, '0, 12'd2047);

        // Drain, then give stray results a chance to show up
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
